@@ rtl/grdda_pkg.sv @@
// Package for the grid ray DDA stepper: payload structs, register indexes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package grdda_pkg;

    localparam int MAP_CELLS_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_NUM_W = 33;
    localparam int DIV_CNT_W = 6;

    localparam logic [REG_IDX_W-1:0] REG_PLAYER_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PLAYER_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIR_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIR_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH = 3'd6;

    localparam logic [11:0] WIDTH_RESET = 12'd1920;

    typedef struct packed {
        logic        kind;
        logic [11:0] column;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         cell_x;
        logic [7:0]         cell_y;
        logic               face;
        logic [31:0]        dist_x;
        logic [31:0]        dist_y;
        logic [31:0]        delta_x;
        logic [31:0]        delta_y;
        logic signed [19:0] ray_x;
        logic signed [19:0] ray_y;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAM_DIV,
        ST_CAM_WAIT,
        ST_RAY_MUL,
        ST_RAY_SUM,
        ST_DX_DIV,
        ST_DX_WAIT,
        ST_DY_DIV,
        ST_DY_WAIT,
        ST_SIDE_MUL,
        ST_SIDE_SAT,
        ST_STEP,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_CAM,
        DIV_DX,
        DIV_DY
    } div_sel_t;

    typedef struct packed {
        logic     latch_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     cam_store;
        logic     ray_mul;
        logic     ray_sum;
        logic     dx_store;
        logic     dy_store;
        logic     side_mul;
        logic     side_sat;
        logic     step;
    } dp_cmd_t;

    typedef struct packed {
        logic kind;
        logic div_done;
    } dp_stat_t;

endpackage

@@ rtl/grdda_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on grdda_pkg.
module grdda_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [grdda_pkg::DIV_NUM_W-1:0]    num,
    input  logic [19:0]                        den,
    output logic                               done,
    output logic [grdda_pkg::DIV_NUM_W-1:0]    quot
);

    localparam int NW = grdda_pkg::DIV_NUM_W;

    logic [NW-1:0] quot_reg, quot_next;
    logic [20:0] rem_reg, rem_next;
    logic [19:0] den_reg, den_next;
    logic [grdda_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [20:0] trial;
    logic [21:0] diff;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[19:0], quot_reg[NW-1]};
        diff = {1'b0, trial} - {2'b00, den_reg};
        if (start)
        begin
            quot_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = grdda_pkg::DIV_CNT_W'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[21])
            begin
                rem_next = diff[20:0];
                quot_next = {quot_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quot_next = {quot_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == grdda_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ rtl/grdda_ctrl.sv @@
// Controller state machine for the grid ray DDA stepper.
// Depends on grdda_pkg.
module grdda_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  grdda_pkg::dp_stat_t    stat,
    output grdda_pkg::dp_cmd_t     cmd
);

    grdda_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grdda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.div_sel = grdda_pkg::DIV_CAM;
        in_stall = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            grdda_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = grdda_pkg::ST_CAM_DIV;
                end
            end
            grdda_pkg::ST_CAM_DIV:
            begin
                if (stat.kind)
                begin
                    state_next = grdda_pkg::ST_STEP;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = grdda_pkg::ST_CAM_WAIT;
                end
            end
            grdda_pkg::ST_CAM_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.cam_store = 1'b1;
                    state_next = grdda_pkg::ST_RAY_MUL;
                end
            end
            grdda_pkg::ST_RAY_MUL:
            begin
                cmd.ray_mul = 1'b1;
                state_next = grdda_pkg::ST_RAY_SUM;
            end
            grdda_pkg::ST_RAY_SUM:
            begin
                cmd.ray_sum = 1'b1;
                state_next = grdda_pkg::ST_DX_DIV;
            end
            grdda_pkg::ST_DX_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel = grdda_pkg::DIV_DX;
                state_next = grdda_pkg::ST_DX_WAIT;
            end
            grdda_pkg::ST_DX_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.dx_store = 1'b1;
                    state_next = grdda_pkg::ST_DY_DIV;
                end
            end
            grdda_pkg::ST_DY_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel = grdda_pkg::DIV_DY;
                state_next = grdda_pkg::ST_DY_WAIT;
            end
            grdda_pkg::ST_DY_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.dy_store = 1'b1;
                    state_next = grdda_pkg::ST_SIDE_MUL;
                end
            end
            grdda_pkg::ST_SIDE_MUL:
            begin
                cmd.side_mul = 1'b1;
                state_next = grdda_pkg::ST_SIDE_SAT;
            end
            grdda_pkg::ST_SIDE_SAT:
            begin
                cmd.side_sat = 1'b1;
                state_next = grdda_pkg::ST_OUT;
            end
            grdda_pkg::ST_STEP:
            begin
                cmd.step = 1'b1;
                state_next = grdda_pkg::ST_OUT;
            end
            grdda_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = grdda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = grdda_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == grdda_pkg::ST_CAM_WAIT
            || state_reg == grdda_pkg::ST_DX_WAIT || state_reg == grdda_pkg::ST_DY_WAIT))
        else $error("divider started outside a wait sequence");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");
`endif

endmodule

@@ rtl/grdda_dp.sv @@
// Datapath for the grid ray DDA stepper: configuration registers, ray state,
// multipliers, saturation and stepping. Depends on grdda_pkg and grdda_div.
module grdda_dp #(
    parameter int MAP_CELLS = grdda_pkg::MAP_CELLS_DEF,
    parameter int FRAC_BITS = grdda_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [grdda_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [grdda_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  grdda_pkg::in_item_t                   in_item,
    input  grdda_pkg::dp_cmd_t                    cmd,
    output grdda_pkg::dp_stat_t                   stat,
    output grdda_pkg::out_item_t                  out_item
);

    localparam int CW = $clog2(MAP_CELLS);
    localparam int NW = grdda_pkg::DIV_NUM_W;
    localparam logic [31:0] SAT = 32'hFFFF_FFFF;
    localparam logic signed [34:0] ONE_S = 35'sd1 <<< FRAC_BITS;

    logic [23:0] pos_x_reg, pos_y_reg;
    logic signed [19:0] dir_x_reg, dir_y_reg, pl_x_reg, pl_y_reg;
    logic [11:0] width_reg;

    logic kind_reg;
    logic [11:0] col_reg;
    logic signed [34:0] cam_reg;
    logic signed [55:0] prod_x_reg, prod_y_reg;
    logic [49:0] side_x_reg, side_y_reg;
    logic [7:0] cell_x_reg, cell_y_reg;
    logic neg_x_reg, neg_y_reg, face_reg;
    logic [31:0] acc_x_reg, acc_y_reg, dlt_x_reg, dlt_y_reg;
    logic signed [19:0] ray_x_reg, ray_y_reg;

    logic div_done;
    logic [NW-1:0] div_quot, div_num;
    logic [19:0] div_den;
    logic [11:0] w_eff;
    logic signed [35:0] sum_x, sum_y;
    logic [19:0] mag_x, mag_y;
    logic [FRAC_BITS:0] span_x, span_y;
    logic [32:0] add_x, add_y;
    logic [31:0] quot_sat;

    function automatic logic signed [19:0] sat20(input logic signed [35:0] v);
        if (v > 36'sd524287)
        begin
            return 20'sh7FFFF;
        end
        else if (v < -36'sd524288)
        begin
            return 20'sh80000;
        end
        return v[19:0];
    endfunction

    function automatic logic [19:0] mag20(input logic signed [19:0] v);
        logic [20:0] e;
        e = v[19] ? -{v[19], v} : {v[19], v};
        return e[19:0];
    endfunction

    function automatic logic [7:0] wrap(input logic [7:0] c, input logic neg);
        logic [CW-1:0] n;
        n = neg ? c[CW-1:0] - 1'b1 : c[CW-1:0] + 1'b1;
        return 8'(n);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            dir_x_reg <= 20'(ONE_S);
            dir_y_reg <= '0;
            pl_x_reg <= '0;
            pl_y_reg <= '0;
            width_reg <= grdda_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                grdda_pkg::REG_PLAYER_X: pos_x_reg <= cfg_data;
                grdda_pkg::REG_PLAYER_Y: pos_y_reg <= cfg_data;
                grdda_pkg::REG_DIR_X:    dir_x_reg <= cfg_data[19:0];
                grdda_pkg::REG_DIR_Y:    dir_y_reg <= cfg_data[19:0];
                grdda_pkg::REG_PLANE_X:  pl_x_reg <= cfg_data[19:0];
                grdda_pkg::REG_PLANE_Y:  pl_y_reg <= cfg_data[19:0];
                grdda_pkg::REG_WIDTH:    width_reg <= cfg_data[11:0];
                default:                 ;
            endcase
        end
    end

    assign w_eff = (width_reg == '0) ? 12'd1 : width_reg;
    assign mag_x = mag20(ray_x_reg);
    assign mag_y = mag20(ray_y_reg);

    always_comb
    begin
        unique case (cmd.div_sel)
            grdda_pkg::DIV_CAM:
            begin
                div_num = NW'({8'd0, col_reg, 1'b0}) << FRAC_BITS;
                div_den = {8'd0, w_eff};
            end
            grdda_pkg::DIV_DX:
            begin
                div_num = NW'(1) << (2 * FRAC_BITS);
                div_den = mag_x;
            end
            default:
            begin
                div_num = NW'(1) << (2 * FRAC_BITS);
                div_den = mag_y;
            end
        endcase
    end

    grdda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign quot_sat = div_quot[NW-1] ? SAT : div_quot[31:0];
    assign sum_x = 36'(dir_x_reg) + 36'(prod_x_reg >>> FRAC_BITS);
    assign sum_y = 36'(dir_y_reg) + 36'(prod_y_reg >>> FRAC_BITS);
    assign span_x = ray_x_reg[19] ? {1'b0, pos_x_reg[FRAC_BITS-1:0]}
        : (FRAC_BITS+1)'(ONE_S) - {1'b0, pos_x_reg[FRAC_BITS-1:0]};
    assign span_y = ray_y_reg[19] ? {1'b0, pos_y_reg[FRAC_BITS-1:0]}
        : (FRAC_BITS+1)'(ONE_S) - {1'b0, pos_y_reg[FRAC_BITS-1:0]};
    assign add_x = {1'b0, acc_x_reg} + {1'b0, dlt_x_reg};
    assign add_y = {1'b0, acc_y_reg} + {1'b0, dlt_y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_x_reg <= '0;
            cell_y_reg <= '0;
            neg_x_reg <= 1'b0;
            neg_y_reg <= 1'b0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            dlt_x_reg <= '0;
            dlt_y_reg <= '0;
            ray_x_reg <= '0;
            ray_y_reg <= '0;
            face_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ray_sum)
            begin
                ray_x_reg <= sat20(sum_x);
                ray_y_reg <= sat20(sum_y);
            end
            if (cmd.dx_store)
            begin
                dlt_x_reg <= (ray_x_reg == '0) ? SAT : quot_sat;
            end
            if (cmd.dy_store)
            begin
                dlt_y_reg <= (ray_y_reg == '0) ? SAT : quot_sat;
            end
            if (cmd.side_sat)
            begin
                acc_x_reg <= (|side_x_reg[49:32]) ? SAT : side_x_reg[31:0];
                acc_y_reg <= (|side_y_reg[49:32]) ? SAT : side_y_reg[31:0];
                cell_x_reg <= 8'(pos_x_reg[FRAC_BITS +: CW]);
                cell_y_reg <= 8'(pos_y_reg[FRAC_BITS +: CW]);
                neg_x_reg <= ray_x_reg[19];
                neg_y_reg <= ray_y_reg[19];
                face_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                if (acc_x_reg < acc_y_reg)
                begin
                    acc_x_reg <= add_x[32] ? SAT : add_x[31:0];
                    cell_x_reg <= wrap(cell_x_reg, neg_x_reg);
                    face_reg <= 1'b0;
                end
                else
                begin
                    acc_y_reg <= add_y[32] ? SAT : add_y[31:0];
                    cell_y_reg <= wrap(cell_y_reg, neg_y_reg);
                    face_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            kind_reg <= in_item.kind;
            col_reg <= in_item.column;
        end
        if (cmd.cam_store)
        begin
            cam_reg <= 35'(div_quot[33-1:0]) - ONE_S;
        end
        if (cmd.ray_mul)
        begin
            prod_x_reg <= 56'(pl_x_reg) * 56'(cam_reg);
            prod_y_reg <= 56'(pl_y_reg) * 56'(cam_reg);
        end
        if (cmd.side_mul)
        begin
            side_x_reg <= (50'(span_x) * 50'(dlt_x_reg)) >> FRAC_BITS;
            side_y_reg <= (50'(span_y) * 50'(dlt_y_reg)) >> FRAC_BITS;
        end
    end

    assign stat.kind = kind_reg;
    assign stat.div_done = div_done;

    assign out_item.cell_x = cell_x_reg;
    assign out_item.cell_y = cell_y_reg;
    assign out_item.face = face_reg;
    assign out_item.dist_x = acc_x_reg;
    assign out_item.dist_y = acc_y_reg;
    assign out_item.delta_x = dlt_x_reg;
    assign out_item.delta_y = dlt_y_reg;
    assign out_item.ray_x = ray_x_reg;
    assign out_item.ray_y = ray_y_reg;

endmodule

@@ rtl/grid_ray_dda_stepper.sv @@
// A step item is accepted in the idle state, passes the camera-divide state, where
// its kind is checked, and the step state, and its result is then offered. The next
// item is accepted the cycle after the result is taken. A start item's result is
// offered after three passes of the shared bit-serial divider, for the camera offset
// and the two reciprocal deltas, each followed by storing its quotient, and after
// the ray multiply, ray sum, side multiply and side saturate steps. One item is in
// flight at a time.
module grid_ray_dda_stepper #(
    parameter int MAP_CELLS = grdda_pkg::MAP_CELLS_DEF,
    parameter int FRAC_BITS = grdda_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [grdda_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [grdda_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  grdda_pkg::in_item_t                in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output grdda_pkg::out_item_t               out_data
);

    grdda_pkg::dp_cmd_t cmd;
    grdda_pkg::dp_stat_t stat;

    grdda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    grdda_dp #(
        .MAP_CELLS (MAP_CELLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_data)
    );

endmodule

@@ test/grid_ray_dda_stepper_tb.sv @@
// Testbench for grid_ray_dda_stepper: drives start and step items with random idling and
// compares every result with a local fixed-point ray traversal predictor.
// Depends on grdda_pkg and the grid_ray_dda_stepper RTL.
`timescale 1ns / 100ps

module grid_ray_dda_stepper_tb;

    localparam longint ONE_Q = 64'd65536;
    localparam longint SAT_Q = 64'hFFFF_FFFF;
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP = 1'b1;
    localparam logic [grdda_pkg::REG_IDX_W-1:0] REG_NONE = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [grdda_pkg::REG_IDX_W-1:0] cfg_index;
    logic [grdda_pkg::CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    grdda_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    grdda_pkg::out_item_t out_data;

    grid_ray_dda_stepper DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data)
    );

    logic [23:0] pos_x, pos_y;
    logic signed [19:0] dir_x, dir_y, plane_x, plane_y;
    logic [11:0] width_reg;

    logic [7:0] cell_x_m, cell_y_m;
    logic neg_x_m, neg_y_m;
    logic [31:0] side_x_m, side_y_m, delta_x_m, delta_y_m;
    logic signed [19:0] ray_x_m, ray_y_m;

    grdda_pkg::out_item_t expected_results[$];
    int errors = 0;
    int starts_sent = 0;
    int steps_sent = 0;
    int results_seen = 0;
    bit quiet = 0;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("Timeout waiting for results");
        $display("FAILURE");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        if (errors <= 40)
            $display("Mismatch at result %0d on %s: got %0h, expected %0h",
                     results_seen, what, got, want);
    endtask

    function automatic logic signed [19:0] sat_ray(input longint v);
        if (v > 524287)
            return 20'sd524287;
        if (v < -524288)
            return -20'sd524288;
        return v[19:0];
    endfunction

    function automatic logic [31:0] sat_dist(input longint unsigned v);
        return (v > SAT_Q) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] boundary_spacing(input logic signed [19:0] r);
        longint unsigned mag;
        if (r == 0)
            return 32'hFFFF_FFFF;
        mag = (r < 0) ? -longint'(r) : longint'(r);
        return sat_dist((64'd1 << 32) / mag);
    endfunction

    function automatic logic [31:0] first_side(input logic [23:0] pos, input logic neg,
                                               input logic [31:0] delta);
        longint unsigned f;
        longint unsigned span;
        f = longint'(pos[15:0]);
        span = neg ? f : ONE_Q - f;
        return sat_dist((span * longint'(delta)) >> 16);
    endfunction

    task automatic predict_item(input grdda_pkg::in_item_t item);
        grdda_pkg::out_item_t r;
        longint unsigned w;
        longint cam;
        r.face = 0;
        if (item.kind == KIND_START)
        begin
            w = (width_reg == 0) ? 1 : width_reg;
            cam = longint'(((64'd2 * item.column) << 16) / w) - ONE_Q;
            ray_x_m = sat_ray(longint'(dir_x) + ((longint'(plane_x) * cam) >>> 16));
            ray_y_m = sat_ray(longint'(dir_y) + ((longint'(plane_y) * cam) >>> 16));
            delta_x_m = boundary_spacing(ray_x_m);
            delta_y_m = boundary_spacing(ray_y_m);
            neg_x_m = ray_x_m < 0;
            neg_y_m = ray_y_m < 0;
            cell_x_m = pos_x[23:16];
            cell_y_m = pos_y[23:16];
            side_x_m = first_side(pos_x, neg_x_m, delta_x_m);
            side_y_m = first_side(pos_y, neg_y_m, delta_y_m);
        end
        else if (side_x_m < side_y_m)
        begin
            side_x_m = sat_dist(longint'(side_x_m) + longint'(delta_x_m));
            cell_x_m = neg_x_m ? cell_x_m - 8'd1 : cell_x_m + 8'd1;
        end
        else
        begin
            side_y_m = sat_dist(longint'(side_y_m) + longint'(delta_y_m));
            cell_y_m = neg_y_m ? cell_y_m - 8'd1 : cell_y_m + 8'd1;
            r.face = 1;
        end
        r.cell_x = cell_x_m;
        r.cell_y = cell_y_m;
        r.dist_x = side_x_m;
        r.dist_y = side_y_m;
        r.delta_x = delta_x_m;
        r.delta_y = delta_y_m;
        r.ray_x = ray_x_m;
        r.ray_y = ray_y_m;
        expected_results.push_back(r);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge clk);
    endtask

    // The item stays valid after acceptance; the caller either sends the next item,
    // which may first drop valid for a random idle, or drains, which drops valid.
    task automatic send_item(input logic kind, input logic [11:0] column);
        grdda_pkg::in_item_t item;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            in_data <= 13'($urandom);
            idle_cycles($urandom_range(1, 18));
        end
        item.kind = kind;
        item.column = column;
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(item);
        if (kind == KIND_START)
            starts_sent++;
        else
            steps_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        in_data <= 13'($urandom);
        while (expected_results.size() != 0)
            @(posedge clk);
        idle_cycles(10);
    endtask

    // The write enable stays high after the write; the caller drops it after the
    // last write of a group.
    task automatic write_reg(input logic [grdda_pkg::REG_IDX_W-1:0] idx,
                             input logic [23:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            grdda_pkg::REG_PLAYER_X: pos_x = value;
            grdda_pkg::REG_PLAYER_Y: pos_y = value;
            grdda_pkg::REG_DIR_X: dir_x = value[19:0];
            grdda_pkg::REG_DIR_Y: dir_y = value[19:0];
            grdda_pkg::REG_PLANE_X: plane_x = value[19:0];
            grdda_pkg::REG_PLANE_Y: plane_y = value[19:0];
            grdda_pkg::REG_WIDTH: width_reg = value[11:0];
            default: ;
        endcase
    endtask

    task automatic write_view(input logic [23:0] px, input logic [23:0] py,
                              input logic [19:0] dx, input logic [19:0] dy,
                              input logic [19:0] cx, input logic [19:0] cy,
                              input logic [11:0] w);
        write_reg(grdda_pkg::REG_PLAYER_X, px);
        write_reg(grdda_pkg::REG_PLAYER_Y, py);
        write_reg(grdda_pkg::REG_DIR_X, {4'd0, dx});
        write_reg(grdda_pkg::REG_DIR_Y, {4'd0, dy});
        write_reg(grdda_pkg::REG_PLANE_X, {4'd0, cx});
        write_reg(grdda_pkg::REG_PLANE_Y, {4'd0, cy});
        write_reg(grdda_pkg::REG_WIDTH, {12'd0, w});
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            grdda_pkg::out_item_t e;
            results_seen++;
            if (expected_results.size() == 0)
                report("unexpected result", 0, 0);
            else
            begin
                e = expected_results.pop_front();
                if (out_data.cell_x !== e.cell_x)
                    report("cell_x", longint'(out_data.cell_x), longint'(e.cell_x));
                if (out_data.cell_y !== e.cell_y)
                    report("cell_y", longint'(out_data.cell_y), longint'(e.cell_y));
                if (out_data.face !== e.face)
                    report("face", longint'(out_data.face), longint'(e.face));
                if (out_data.dist_x !== e.dist_x)
                    report("dist_x", longint'(out_data.dist_x), longint'(e.dist_x));
                if (out_data.dist_y !== e.dist_y)
                    report("dist_y", longint'(out_data.dist_y), longint'(e.dist_y));
                if (out_data.delta_x !== e.delta_x)
                    report("delta_x", longint'(out_data.delta_x), longint'(e.delta_x));
                if (out_data.delta_y !== e.delta_y)
                    report("delta_y", longint'(out_data.delta_y), longint'(e.delta_y));
                if (out_data.ray_x !== e.ray_x)
                    report("ray_x", longint'(out_data.ray_x[19:0]), longint'(e.ray_x[19:0]));
                if (out_data.ray_y !== e.ray_y)
                    report("ray_y", longint'(out_data.ray_y[19:0]), longint'(e.ray_y[19:0]));
            end
        end
    end

    initial
    begin
        int n;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    task automatic test_reset_state();
        pos_x = 0;
        pos_y = 0;
        dir_x = 20'sd65536;
        dir_y = 0;
        plane_x = 0;
        plane_y = 0;
        width_reg = grdda_pkg::WIDTH_RESET;
        cell_x_m = 0;
        cell_y_m = 0;
        neg_x_m = 0;
        neg_y_m = 0;
        side_x_m = 0;
        side_y_m = 0;
        delta_x_m = 0;
        delta_y_m = 0;
        ray_x_m = 0;
        ray_y_m = 0;
        send_item(KIND_STEP, 12'hFFF);
        send_item(KIND_STEP, 12'h000);
        send_item(KIND_START, 12'd960);
        send_item(KIND_STEP, 12'd0);
        drain();
    endtask

    task automatic test_directed();
        write_view(24'h000000, 24'hFFFFFF, 20'sd65536, 20'sd0, 20'sd0, 20'sd43690, 12'd0);
        send_item(KIND_START, 12'd0);
        send_item(KIND_STEP, 12'd0);
        send_item(KIND_START, 12'hFFF);
        send_item(KIND_STEP, 12'd0);
        drain();
        write_reg(grdda_pkg::REG_WIDTH, 24'h000FFF);
        write_reg(REG_NONE, 24'h123456);
        cfg_we <= 1'b0;
        send_item(KIND_START, 12'd2047);
        repeat (3) send_item(KIND_STEP, 12'd0);
        drain();
        write_view(24'hFFFFFF, 24'h000000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h80000,
                   12'd1);
        send_item(KIND_START, 12'd0);
        send_item(KIND_START, 12'd1);
        send_item(KIND_START, 12'd4095);
        repeat (3) send_item(KIND_STEP, 12'd0);
        drain();
        write_view(24'h7F8000, 24'h018000, 20'sd1, 20'sd0, 20'sd0, 20'sd0, 12'd64);
        send_item(KIND_START, 12'd32);
        repeat (6) send_item(KIND_STEP, 12'd0);
        drain();
    endtask

    task automatic test_random();
        logic [19:0] v[4];
        for (int phase = 0; phase < 12; phase++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                case ($urandom_range(0, 3))
                    0: v[k] = 20'($urandom);
                    1: v[k] = $urandom_range(0, 2) == 0 ? 20'd0
                              : 20'($urandom_range(0, 131072) - 65536);
                    2: v[k] = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
                    default: v[k] = 20'($urandom_range(0, 512) - 256);
                endcase
            end
            write_view(24'($urandom), 24'($urandom), v[0], v[1], v[2], v[3],
                       $urandom_range(0, 5) == 0 ? 12'($urandom)
                       : 12'($urandom_range(1, 4095)));
            for (int r = 0; r < 12; r++)
            begin
                send_item(KIND_START, $urandom_range(0, 7) == 0 ? 12'($urandom)
                          : 12'($urandom_range(0, width_reg)));
                repeat ($urandom_range(0, 10)) send_item(KIND_STEP, 12'($urandom));
            end
            drain();
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1;
        write_view(24'($urandom), 24'($urandom), 20'sd65536, 20'sd30000, -20'sd20000,
                   20'sd43690, 12'd320);
        for (int r = 0; r < 8; r++)
        begin
            send_item(KIND_START, 12'($urandom_range(0, 319)));
            repeat (12) send_item(KIND_STEP, 12'd0);
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        idle_cycles(3);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed();
        test_random();
        test_back_to_back();
        $display("Sent %0d start items and %0d step items, checked %0d results.",
                 starts_sent, steps_sent, results_seen);
        $display("Covered register extremes, zero width, wide columns and cell wrap.");
        if (errors == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/grdda_pkg.sv
rtl/grdda_div.sv
rtl/grdda_ctrl.sv
rtl/grdda_dp.sv
rtl/grid_ray_dda_stepper.sv
test/grid_ray_dda_stepper_tb.sv
